[rtl/mfsp_pkg.sv]
// shared types, codes and the request crc table for the sensor poll unit
package mfsp_pkg;

  // operation codes of an input item
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_RX_BYTE = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  // outcome status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_HEADER  = 2'd2;
  localparam logic [1:0] ST_CRC     = 2'd3;

  // result kinds
  localparam logic KIND_REQ     = 1'b0;
  localparam logic KIND_OUTCOME = 1'b1;

  // receive phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  // frame constants
  localparam logic [7:0]  FC_READ_HOLD    = 8'h03;
  localparam logic [7:0]  REQ_COUNT_LO    = 8'h02;
  localparam logic [7:0]  RESP_BYTE_COUNT = 8'h04;
  localparam logic [7:0]  FAIL_MAX        = 8'hFF;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [3:0]  FRAME_LEN       = 4'd9;
  localparam logic [3:0]  CRC_BYTES       = 4'd7;
  localparam logic [2:0]  REQ_LAST_IDX    = 3'd7;

  typedef logic [15:0] crc_tbl_t [256];

  // result handed from the receive core to the output stage
  typedef struct packed {
    logic        emit_req;
    logic        emit_out;
    logic [1:0]  status;
    logic [7:0]  address;
    logic [15:0] hum;
    logic [15:0] temp;
    logic [7:0]  fails;
  } mfsp_res_t;

  // reflected crc-16 update over one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // request crc for every slave address, built at elaboration
  function automatic crc_tbl_t build_req_crc();
    crc_tbl_t    t;
    logic [15:0] c;
    for (int a = 0; a < 256; a++) begin
      c = crc_byte(CRC_INIT, 8'(a));
      c = crc_byte(c, FC_READ_HOLD);
      c = crc_byte(c, 8'h00);
      c = crc_byte(c, 8'h00);
      c = crc_byte(c, 8'h00);
      c = crc_byte(c, REQ_COUNT_LO);
      t[a] = c;
    end
    return t;
  endfunction

  localparam crc_tbl_t REQ_CRC_TBL = build_req_crc();

endpackage

[rtl/mfsp_rx_core.sv]
// poll state, reply frame collection, frame checks and failure counter
module mfsp_rx_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [1:0]          op_i,
  input  logic [7:0]          addr_i,
  input  logic [7:0]          rx_i,
  input  logic [7:0]          ctrl_addr_i,
  output mfsp_pkg::mfsp_res_t res_o
);

  logic [1:0]  phase_q, phase_d;
  logic [7:0]  exp_addr_q, exp_addr_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  fails_q, fails_d;
  logic [7:0]  frame_q [8];

  logic        rx_take;
  logic        frame_end;
  logic        to_take;
  logic        hdr_ok;
  logic        crc_ok;
  logic [1:0]  st;
  logic [7:0]  fails_next;

  // which ops act in the current phase
  assign rx_take   = (op_i == mfsp_pkg::OP_RX_BYTE) && (phase_q == mfsp_pkg::PH_WAIT)
                     && (cnt_q < mfsp_pkg::FRAME_LEN);
  assign frame_end = rx_take && (cnt_q == mfsp_pkg::FRAME_LEN - 4'd1);
  assign to_take   = (op_i == mfsp_pkg::OP_TIMEOUT) && (phase_q == mfsp_pkg::PH_WAIT);

  // frame checks on the ninth byte; the ninth byte itself is rx_i
  assign hdr_ok = (frame_q[0] == exp_addr_q) && (frame_q[1] == mfsp_pkg::FC_READ_HOLD)
                  && (frame_q[2] == mfsp_pkg::RESP_BYTE_COUNT);
  assign crc_ok = ({rx_i, frame_q[7]} == crc_q);

  always_comb begin
    if (to_take) begin
      st = mfsp_pkg::ST_TIMEOUT;
    end else if (!hdr_ok) begin
      st = mfsp_pkg::ST_HEADER;
    end else if (!crc_ok) begin
      st = mfsp_pkg::ST_CRC;
    end else begin
      st = mfsp_pkg::ST_OK;
    end
  end

  // failure counter after this outcome
  always_comb begin
    fails_next = fails_q;
    if (exp_addr_q == ctrl_addr_i) begin
      if (st == mfsp_pkg::ST_OK) begin
        fails_next = 8'd0;
      end else if (fails_q != mfsp_pkg::FAIL_MAX) begin
        fails_next = fails_q + 8'd1;
      end
    end
  end

  // result descriptor
  always_comb begin
    res_o.emit_req = (op_i == mfsp_pkg::OP_START);
    res_o.emit_out = frame_end || to_take;
    res_o.status   = st;
    res_o.address  = res_o.emit_req ? addr_i : exp_addr_q;
    res_o.fails    = fails_next;
    if (!to_take && (st == mfsp_pkg::ST_OK)) begin
      res_o.hum  = {frame_q[3], frame_q[4]};
      res_o.temp = {frame_q[5], frame_q[6]};
    end else begin
      res_o.hum  = 16'd0;
      res_o.temp = 16'd0;
    end
  end

  // next state
  always_comb begin
    phase_d    = phase_q;
    exp_addr_d = exp_addr_q;
    cnt_d      = cnt_q;
    crc_d      = crc_q;
    fails_d    = fails_q;
    if (fire_i) begin
      case (op_i)
        mfsp_pkg::OP_START: begin
          phase_d    = mfsp_pkg::PH_WAIT;
          exp_addr_d = addr_i;
          cnt_d      = 4'd0;
          crc_d      = mfsp_pkg::CRC_INIT;
        end
        mfsp_pkg::OP_RX_BYTE: begin
          if (rx_take) begin
            cnt_d = cnt_q + 4'd1;
            if (cnt_q < mfsp_pkg::CRC_BYTES) begin
              crc_d = mfsp_pkg::crc_byte(crc_q, rx_i);
            end
            if (frame_end) begin
              phase_d = mfsp_pkg::PH_DONE;
              fails_d = fails_next;
            end
          end
        end
        mfsp_pkg::OP_TIMEOUT: begin
          if (to_take) begin
            phase_d = mfsp_pkg::PH_IDLE;
            fails_d = fails_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= mfsp_pkg::PH_IDLE;
      exp_addr_q <= 8'd0;
      cnt_q      <= 4'd0;
      crc_q      <= mfsp_pkg::CRC_INIT;
      fails_q    <= 8'd0;
    end else begin
      phase_q    <= phase_d;
      exp_addr_q <= exp_addr_d;
      cnt_q      <= cnt_d;
      crc_q      <= crc_d;
      fails_q    <= fails_d;
    end
  end

  // reply bytes 0..7; byte 8 is checked straight from the input
  always_ff @(posedge clk_i) begin
    if (fire_i && rx_take && !cnt_q[3]) begin
      frame_q[cnt_q[2:0]] <= rx_i;
    end
  end

endmodule

[rtl/mfsp_out_stage.sv]
// result register with the eight-byte request sequencer
module mfsp_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  mfsp_pkg::mfsp_res_t res_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                kind_o,
  output logic [7:0]          tx_byte_o,
  output logic                last_byte_o,
  output logic [1:0]          status_o,
  output logic [7:0]          polled_address_o,
  output logic signed [15:0]  humidity_tenths_o,
  output logic signed [15:0]  temperature_tenths_o,
  output logic [7:0]          failure_count_o
);

  logic        valid_q;
  logic        kind_q;
  logic [2:0]  idx_q;
  logic [1:0]  status_q;
  logic [7:0]  addr_q;
  logic [15:0] crc_q;
  logic [15:0] hum_q;
  logic [15:0] temp_q;
  logic [7:0]  fails_q;
  logic        run_end;
  logic [7:0]  req_byte;

  assign run_end = (kind_q == mfsp_pkg::KIND_OUTCOME) || (idx_q == mfsp_pkg::REQ_LAST_IDX);
  assign free_o  = !valid_q || (out_ready_i && run_end);

  // valid and byte index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 3'd0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= 3'd0;
    end else if (valid_q && out_ready_i) begin
      if (run_end) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      kind_q   <= res_i.emit_req ? mfsp_pkg::KIND_REQ : mfsp_pkg::KIND_OUTCOME;
      status_q <= res_i.status;
      addr_q   <= res_i.address;
      crc_q    <= mfsp_pkg::REQ_CRC_TBL[res_i.address];
      hum_q    <= res_i.hum;
      temp_q   <= res_i.temp;
      fails_q  <= res_i.fails;
    end
  end

  // request byte by position
  always_comb begin
    case (idx_q)
      3'd0:    req_byte = addr_q;
      3'd1:    req_byte = mfsp_pkg::FC_READ_HOLD;
      3'd5:    req_byte = mfsp_pkg::REQ_COUNT_LO;
      3'd6:    req_byte = crc_q[7:0];
      3'd7:    req_byte = crc_q[15:8];
      default: req_byte = 8'h00;
    endcase
  end

  // output fields
  always_comb begin
    out_valid_o      = valid_q;
    kind_o           = kind_q;
    polled_address_o = addr_q;
    if (kind_q == mfsp_pkg::KIND_REQ) begin
      tx_byte_o            = req_byte;
      last_byte_o          = (idx_q == mfsp_pkg::REQ_LAST_IDX);
      status_o             = mfsp_pkg::ST_OK;
      humidity_tenths_o    = 16'sd0;
      temperature_tenths_o = 16'sd0;
      failure_count_o      = 8'd0;
    end else begin
      tx_byte_o            = 8'h00;
      last_byte_o          = 1'b0;
      status_o             = status_q;
      humidity_tenths_o    = signed'(hum_q);
      temperature_tenths_o = signed'(temp_q);
      failure_count_o      = fails_q;
    end
  end

endmodule

[rtl/modbus_fc03_sensor_poll_unit.sv]
// top level: input register, control address register, receive core and result stage
// Modbus RTU read-holding-registers poll master. Items enter through a one-deep
// input register and are processed one per cycle unless a result waits for the
// result register. A received byte that completes no frame, or an ignored item,
// never waits on the result side. A start item produces eight request bytes
// (address, 0x03, 0, 0, 0, 2, crc low, crc high, the last one marked). They leave
// the result register one per cycle while the output is ready, so a following item
// that itself produces a result waits for that register. The request crc comes from
// an elaboration-time table indexed by slave address. The ninth reply byte or a
// timeout produces one outcome in the cycle after it is processed. The control
// address register takes a write every cycle and should only be written while idle.
module modbus_fc03_sensor_poll_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic [7:0]         slave_address_i,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               kind_o,
  output logic [7:0]         tx_byte_o,
  output logic               last_byte_o,
  output logic [1:0]         status_o,
  output logic [7:0]         polled_address_o,
  output logic signed [15:0] humidity_tenths_o,
  output logic signed [15:0] temperature_tenths_o,
  output logic [7:0]         failure_count_o
);

  logic                cfg_write;
  logic [7:0]          ctrl_q;
  logic                in_valid_q;
  logic [1:0]          op_q;
  logic [7:0]          addr_q;
  logic [7:0]          rx_q;
  logic                out_free;
  logic                fire;
  mfsp_pkg::mfsp_res_t res;

  // control address register
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= 8'd100;
    end else if (cfg_write) begin
      ctrl_q <= cfg_data_i;
    end
  end

  // process the held item unless its result has nowhere to go
  assign fire       = in_valid_q && (!(res.emit_req || res.emit_out) || out_free);
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // input payload on transfer
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q   <= operation_i;
      addr_q <= slave_address_i;
      rx_q   <= rx_byte_i;
    end
  end

  mfsp_rx_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .op_i        (op_q),
    .addr_i      (addr_q),
    .rx_i        (rx_q),
    .ctrl_addr_i (ctrl_q),
    .res_o       (res)
  );

  mfsp_out_stage u_out (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .load_i               (fire && (res.emit_req || res.emit_out)),
    .res_i                (res),
    .free_o               (out_free),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .kind_o               (kind_o),
    .tx_byte_o            (tx_byte_o),
    .last_byte_o          (last_byte_o),
    .status_o             (status_o),
    .polled_address_o     (polled_address_o),
    .humidity_tenths_o    (humidity_tenths_o),
    .temperature_tenths_o (temperature_tenths_o),
    .failure_count_o      (failure_count_o)
  );

endmodule
